>>> rtl/cdrs_pkg.sv
// ----------------------------------------------------------------------------
// cdrs_pkg
// Shared types and constants for the counter delta / reset sync block.
// ----------------------------------------------------------------------------
package cdrs_pkg;

    // Number of remote ports tracked
    localparam int PORTS  = 4;
    localparam int PORT_W = (PORTS > 1) ? $clog2(PORTS) : 1;

    // Field widths
    localparam int REQ_W   = 2;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 16;
    localparam int EPOCH_W = 8;
    localparam int SEQ_W   = 8;
    localparam int STAT_W  = 3;
    localparam int TOTAL_W = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SMALL = 2'd0,
        CFG_MAX_BIG   = 2'd1,
        CFG_SEQ_MASK  = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_idx_t;

    localparam logic [CNT_W-1:0]   MAX_SMALL_RST = 16'd16;
    localparam logic [CNT_W-1:0]   MAX_BIG_RST   = 16'd16;
    localparam logic [SEQ_W-1:0]   SEQ_MASK_RST  = 8'hFF;

    typedef enum logic [REQ_W-1:0] {
        REQ_REPORT = 2'd0,
        REQ_RESET  = 2'd1,
        REQ_MARK   = 2'd2,
        REQ_QUERY  = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_INVALID  = 3'd0,
        ST_PENDING  = 3'd1,
        ST_ACKED    = 3'd2,
        ST_BASELINE = 3'd3,
        ST_RESYNC   = 3'd4,
        ST_NOCHANGE = 3'd5,
        ST_HIT      = 3'd6,
        ST_DONE     = 3'd7
    } status_t;

    typedef struct packed {
        req_t               req_type;
        logic [IDX_W-1:0]   port_index;
        logic [CNT_W-1:0]   small_count;
        logic [CNT_W-1:0]   big_count;
        logic [EPOCH_W-1:0] report_epoch;
        logic               ack_flag;
        logic [SEQ_W-1:0]   sequence_tag;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [CNT_W-1:0]   small_incr;
        logic [CNT_W-1:0]   big_incr;
        logic               port_pending;
        logic [EPOCH_W-1:0] current_epoch;
        logic [TOTAL_W-1:0] resync_total;
    } result_t;

endpackage

>>> rtl/cdrs_in_stage.sv
// ----------------------------------------------------------------------------
// cdrs_in_stage
// Input register: captures one beat and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module cdrs_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cdrs_pkg::item_t s_item,
    input  logic          advance,
    output logic          item_valid,
    output cdrs_pkg::item_t item
);
    import cdrs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept a new beat when empty or when the held beat moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/cdrs_core.sv
// ----------------------------------------------------------------------------
// cdrs_core
// Per-port baseline state, epoch and resync tracking; computes one result.
// ----------------------------------------------------------------------------
module cdrs_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cdrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdrs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            fire,
    input  cdrs_pkg::item_t                 item,
    output cdrs_pkg::result_t               result
);
    import cdrs_pkg::*;

    // Configuration
    logic [CNT_W-1:0] max_small_reg;
    logic [CNT_W-1:0] max_big_reg;
    logic [SEQ_W-1:0] seq_mask_reg;

    // Per-port payload stores
    logic [CNT_W-1:0]   base_small_reg [PORTS];
    logic [CNT_W-1:0]   base_big_reg   [PORTS];
    logic [EPOCH_W-1:0] base_epoch_reg [PORTS];
    logic [SEQ_W-1:0]   sent_seq_reg   [PORTS];

    // Control state
    logic [PORTS-1:0]   base_valid_reg, base_valid_next;
    logic [PORTS-1:0]   pending_reg,    pending_next;
    logic [PORTS-1:0]   sent_reg,       sent_next;
    logic [EPOCH_W-1:0] epoch_reg,      epoch_next;
    logic [TOTAL_W-1:0] resync_reg,     resync_next;

    logic [PORT_W-1:0]  p;
    logic               port_ok;
    logic               ack_ok;
    logic               rebase;
    logic               mark;
    logic [CNT_W-1:0]   dsm;
    logic [CNT_W-1:0]   dbg;
    status_t            status;
    logic [CNT_W-1:0]   small_incr;
    logic [CNT_W-1:0]   big_incr;

    // Decode the addressed port
    assign p       = item.port_index[PORT_W-1:0];
    assign port_ok = ({1'b0, item.port_index} < (IDX_W+1)'(PORTS));

    // Acknowledge match and modulo deltas against the baseline
    assign ack_ok = (item.report_epoch == epoch_reg) && item.ack_flag && sent_reg[p] &&
                    ((item.sequence_tag & seq_mask_reg) == (sent_seq_reg[p] & seq_mask_reg));
    assign dsm    = item.small_count - base_small_reg[p];
    assign dbg    = item.big_count - base_big_reg[p];

    // Next state and status for the held beat
    always_comb begin
        base_valid_next = base_valid_reg;
        pending_next    = pending_reg;
        sent_next       = sent_reg;
        epoch_next      = epoch_reg;
        resync_next     = resync_reg;
        rebase          = 1'b0;
        mark            = 1'b0;
        status          = ST_INVALID;
        small_incr      = '0;
        big_incr        = '0;
        if (item.req_type == REQ_RESET) begin
            epoch_next      = epoch_reg + 1'b1;
            pending_next    = '1;
            sent_next       = '0;
            base_valid_next = '0;
            status          = ST_DONE;
        end else if (port_ok) begin
            unique case (item.req_type)
                REQ_REPORT: begin
                    if (pending_reg[p]) begin
                        if (ack_ok) begin
                            rebase          = 1'b1;
                            pending_next[p] = 1'b0;
                            sent_next[p]    = 1'b0;
                            status          = ST_ACKED;
                        end else begin
                            status = ST_PENDING;
                        end
                    end else if (!base_valid_reg[p]) begin
                        rebase = 1'b1;
                        status = ST_BASELINE;
                    end else if (item.report_epoch != base_epoch_reg[p]) begin
                        rebase      = 1'b1;
                        resync_next = resync_reg + 1'b1;
                        status      = ST_RESYNC;
                    end else begin
                        rebase = 1'b1;
                        if ((dsm > max_small_reg) || (dbg > max_big_reg)) begin
                            resync_next = resync_reg + 1'b1;
                            status      = ST_RESYNC;
                        end else if ((dsm == '0) && (dbg == '0)) begin
                            status = ST_NOCHANGE;
                        end else begin
                            small_incr = dsm;
                            big_incr   = dbg;
                            status     = ST_HIT;
                        end
                    end
                    if (rebase) begin
                        base_valid_next[p] = 1'b1;
                    end
                end
                REQ_MARK: begin
                    mark         = 1'b1;
                    sent_next[p] = 1'b1;
                    status       = ST_DONE;
                end
                REQ_QUERY: begin
                    status = ST_DONE;
                end
                default: begin
                    status = ST_DONE;
                end
            endcase
        end
    end

    assign result.status        = status;
    assign result.small_incr    = small_incr;
    assign result.big_incr      = big_incr;
    assign result.port_pending  = port_ok ? pending_next[p] : 1'b0;
    assign result.current_epoch = epoch_next;
    assign result.resync_total  = resync_next;

    // Configuration writes; an unused index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_small_reg <= MAX_SMALL_RST;
            max_big_reg   <= MAX_BIG_RST;
            seq_mask_reg  <= SEQ_MASK_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAX_SMALL: max_small_reg <= cfg_wdata;
                CFG_MAX_BIG:   max_big_reg   <= cfg_wdata;
                CFG_SEQ_MASK:  seq_mask_reg  <= cfg_wdata[SEQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance control state on each consumed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_valid_reg <= '0;
            pending_reg    <= '0;
            sent_reg       <= '0;
            epoch_reg      <= '0;
            resync_reg     <= '0;
        end else if (fire) begin
            base_valid_reg <= base_valid_next;
            pending_reg    <= pending_next;
            sent_reg       <= sent_next;
            epoch_reg      <= epoch_next;
            resync_reg     <= resync_next;
        end
    end

    // Update per-port stores; entries are read only once their valid or sent bit is set
    always_ff @(posedge aclk) begin
        if (fire && rebase) begin
            base_small_reg[p] <= item.small_count;
            base_big_reg[p]   <= item.big_count;
            base_epoch_reg[p] <= item.report_epoch;
        end
        if (fire && mark) begin
            sent_seq_reg[p] <= item.sequence_tag;
        end
    end

    // A reset request leaves every port pending with no baseline
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (item.req_type == REQ_RESET) |=>
            (pending_reg == '1) && (base_valid_reg == '0) && (sent_reg == '0))
        else $error("reset request did not mark all ports pending");

    // A resync bumps the counter by exactly one
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (status == ST_RESYNC) |=> resync_reg == $past(resync_reg) + 1'b1)
        else $error("resync did not advance the resync counter");

    // An acknowledged port leaves pending with a fresh baseline
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (status == ST_ACKED) |=>
            !pending_reg[$past(p)] && base_valid_reg[$past(p)])
        else $error("acknowledge did not clear pending state");

    // The epoch moves only on a reset request
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(fire && (item.req_type == REQ_RESET)) |=> $stable(epoch_reg))
        else $error("epoch changed without a reset request");

endmodule

>>> rtl/counter_delta_reset_sync.sv
// ----------------------------------------------------------------------------
// counter_delta_reset_sync
// Per-port hit-counter delta tracker with epoch-based reset handshake.
// ----------------------------------------------------------------------------
// Path: an accepted beat waits in the input register and moves into the result
// register once that register is free or draining; its result is offered there.
// Throughput: one beat per cycle unless m_ready stalls; per-port update is a single pass.
// Reset (aresetn low, synchronous): clears baselines' valid bits, pending and
// sent bits, epoch, resync count and both channels; limits and mask reload.
module counter_delta_reset_sync (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cdrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdrs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cdrs_pkg::REQ_W-1:0]      s_req_type,
    input  logic [cdrs_pkg::IDX_W-1:0]      s_port_index,
    input  logic [cdrs_pkg::CNT_W-1:0]      s_small_count,
    input  logic [cdrs_pkg::CNT_W-1:0]      s_big_count,
    input  logic [cdrs_pkg::EPOCH_W-1:0]    s_report_epoch,
    input  logic                            s_ack_flag,
    input  logic [cdrs_pkg::SEQ_W-1:0]      s_sequence_tag,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cdrs_pkg::STAT_W-1:0]     m_status,
    output logic [cdrs_pkg::CNT_W-1:0]      m_small_delta,
    output logic [cdrs_pkg::CNT_W-1:0]      m_big_delta,
    output logic                            m_port_pending,
    output logic [cdrs_pkg::EPOCH_W-1:0]    m_current_epoch,
    output logic [cdrs_pkg::TOTAL_W-1:0]    m_resync_total
);
    import cdrs_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    // Pack the input beat
    assign s_item.req_type     = req_t'(s_req_type);
    assign s_item.port_index   = s_port_index;
    assign s_item.small_count  = s_small_count;
    assign s_item.big_count    = s_big_count;
    assign s_item.report_epoch = s_report_epoch;
    assign s_item.ack_flag     = s_ack_flag;
    assign s_item.sequence_tag = s_sequence_tag;

    // Move the held beat when the result register is free or draining
    assign advance = item_valid && (!out_valid_reg || m_ready);

    cdrs_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cdrs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (advance),
        .item      (item),
        .result    (result)
    );

    // Result register
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_reg.status;
    assign m_small_delta   = out_reg.small_incr;
    assign m_big_delta     = out_reg.big_incr;
    assign m_port_pending  = out_reg.port_pending;
    assign m_current_epoch = out_reg.current_epoch;
    assign m_resync_total  = out_reg.resync_total;

    // Deltas are nonzero exactly on a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_HIT) |-> (m_small_delta != '0) || (m_big_delta != '0))
        else $error("hit result with zero deltas");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_HIT) |-> (m_small_delta == '0) && (m_big_delta == '0))
        else $error("nonzero deltas on a non-hit result");

    // An invalid-port result never reports pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_INVALID) |-> !m_port_pending)
        else $error("pending reported for an invalid port");

endmodule
